FILE: rtl/dle_stuffed_frame_receiver_core_defines.svh
// assertion macros for the checker file
`ifndef DLE_STUFFED_FRAME_RECEIVER_CORE_DEFINES_SVH
`define DLE_STUFFED_FRAME_RECEIVER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define DSFR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define DSFR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/dsfr_pkg.sv
// types and constants of the dle stuffed frame receiver
package dsfr_pkg;

   localparam logic [7:0] SYNC_BYTE = 8'h10;
   localparam logic [7:0] END_BYTE  = 8'h03;

   localparam logic [7:0] ID_F5 = 8'hf5;
   localparam logic [7:0] ID_F7 = 8'hf7;
   localparam logic [7:0] ID_E5 = 8'he5;
   localparam logic [7:0] ID_4A = 8'h4a;
   localparam logic [7:0] ID_4B = 8'h4b;

   localparam int INDEX_W  = 12;
   localparam int LENGTH_W = 13;

   typedef enum logic [1:0] {
      EV_NONE     = 2'd0,
      EV_COMPLETE = 2'd1,
      EV_OVERFLOW = 2'd2
   } event_type;

   typedef struct packed {
      logic                byte_kept;
      logic [INDEX_W-1:0]  keep_index;
      logic [7:0]          kept_value;
      event_type           frame_event;
      logic [LENGTH_W-1:0] frame_length;
      logic [7:0]          message_id;
      logic                known_type;
   } rsp_type;

   function automatic logic id_is_known(input logic [7:0] id);
      return (id == ID_F5) || (id == ID_F7) || (id == ID_E5) ||
             (id == ID_4A) || (id == ID_4B);
   endfunction

endpackage

FILE: rtl/dsfr_req_if.sv
// received byte channel
interface dsfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: rtl/dsfr_rsp_if.sv
// per-byte result channel
interface dsfr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          byte_kept;
   logic [dsfr_pkg::INDEX_W-1:0]  keep_index;
   logic [7:0]                    kept_value;
   logic [1:0]                    frame_event;
   logic [dsfr_pkg::LENGTH_W-1:0] frame_length;
   logic [7:0]                    message_id;
   logic                          known_type;

   modport source (output valid, output byte_kept, output keep_index, output kept_value,
                   output frame_event, output frame_length, output message_id,
                   output known_type, input ready);
   modport sink (input valid, input byte_kept, input keep_index, input kept_value,
                 input frame_event, input frame_length, input message_id,
                 input known_type, output ready);
endinterface

FILE: rtl/dsfr_step.sv
// next-state and result logic for one received byte
module dsfr_step #(
   parameter int MAX_FRAME_LEN = 4096
) (
   input  logic [7:0]                      rx_byte,
   input  logic [$clog2(MAX_FRAME_LEN)-1:0] count,
   input  logic                            toggle,
   input  logic [7:0]                      type_byte,
   output logic [$clog2(MAX_FRAME_LEN)-1:0] count_next,
   output logic                            toggle_next,
   output logic [7:0]                      type_next,
   output dsfr_pkg::rsp_type               rsp
);
   localparam int CW = $clog2(MAX_FRAME_LEN);
   localparam logic [CW:0] MAX_C = (CW+1)'(MAX_FRAME_LEN);
   localparam logic [CW-1:0] ONE = CW'(1);
   localparam logic [CW-1:0] TWO = CW'(2);

   logic          is_sync;
   logic          is_end;
   logic          tog_flip;
   logic          keep;
   logic [CW:0]   inc;

   assign is_sync  = (rx_byte == dsfr_pkg::SYNC_BYTE);
   assign is_end   = (rx_byte == dsfr_pkg::END_BYTE);
   assign tog_flip = toggle ^ is_sync;
   // only the first of a doubled sync byte is stored
   assign keep     = !is_sync || tog_flip;
   assign inc      = keep ? ({1'b0, count} + (CW+1)'(1)) : {1'b0, count};

   always_comb begin
      count_next   = count;
      toggle_next  = toggle;
      type_next    = type_byte;
      rsp          = '0;
      rsp.frame_event = dsfr_pkg::EV_NONE;
      if (count == '0 && is_sync) begin
         rsp.byte_kept  = 1'b1;
         rsp.kept_value = rx_byte;
         count_next     = ONE;
      end else if (count == ONE && !is_sync && !is_end) begin
         rsp.byte_kept  = 1'b1;
         rsp.keep_index = dsfr_pkg::INDEX_W'(ONE);
         rsp.kept_value = rx_byte;
         type_next      = rx_byte;
         count_next     = TWO;
         toggle_next    = 1'b0;
      end else begin
         toggle_next = tog_flip;
         if (keep) begin
            rsp.byte_kept  = 1'b1;
            rsp.keep_index = dsfr_pkg::INDEX_W'(count);
            rsp.kept_value = rx_byte;
            if (count == ONE) begin
               type_next = rx_byte;
            end
         end
         if (is_end && tog_flip) begin
            rsp.frame_event  = dsfr_pkg::EV_COMPLETE;
            rsp.frame_length = dsfr_pkg::LENGTH_W'(inc);
            rsp.message_id   = type_next;
            rsp.known_type   = dsfr_pkg::id_is_known(type_next);
            count_next       = '0;
         end else if (inc >= MAX_C) begin
            rsp.frame_event = dsfr_pkg::EV_OVERFLOW;
            count_next      = '0;
         end else begin
            count_next = inc[CW-1:0];
         end
      end
   end
endmodule

FILE: rtl/dle_stuffed_frame_receiver_core.sv
// Receives a byte stream framed as sync 0x10, message id, payload with 0x10 doubled, and the
// ending pair 0x10 0x03. Every accepted byte yields exactly one result item: whether and where
// the byte is stored in the frame, and an event (none, frame complete with length, id and a
// known-type flag, or overflow once MAX_FRAME_LEN bytes are stored). The escape toggle is
// kept across frames and a non-sync byte in idle is stored as byte 0. One byte is taken every
// cycle while no result is held back; a byte goes into the input register when accepted, and
// its result is computed from there into the result register. A result that is held
// back stalls the input once the input register is also full. The byte counter, escape toggle
// and message id updates in the step logic are the only loops.
module dle_stuffed_frame_receiver_core #(
   parameter int MAX_FRAME_LEN = 4096
) (
   input logic       clock,
   input logic       reset,
   dsfr_req_if.sink  req_ch,
   dsfr_rsp_if.source rsp_ch
);
   localparam int CW = $clog2(MAX_FRAME_LEN);

   logic              in_valid_ff;
   logic [7:0]        in_byte_ff;
   logic              rsp_valid_ff;
   dsfr_pkg::rsp_type rsp_data_ff;
   logic [CW-1:0]     count_ff;
   logic              toggle_ff;
   logic [7:0]        type_ff;

   logic [CW-1:0]     count_in;
   logic              toggle_in;
   logic [7:0]        type_in;
   dsfr_pkg::rsp_type rsp_in;
   logic              advance;
   logic              step;

   // result slot frees up when empty or being taken
   assign advance = !rsp_valid_ff || rsp_ch.ready;
   assign step    = in_valid_ff && advance;
   assign req_ch.ready = !in_valid_ff || advance;

   dsfr_step #(
      .MAX_FRAME_LEN(MAX_FRAME_LEN)
   ) u_step (
      .rx_byte     (in_byte_ff),
      .count       (count_ff),
      .toggle      (toggle_ff),
      .type_byte   (type_ff),
      .count_next  (count_in),
      .toggle_next (toggle_in),
      .type_next   (type_in),
      .rsp         (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         toggle_ff    <= 1'b0;
         type_ff      <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            in_valid_ff <= 1'b1;
            in_byte_ff  <= req_ch.rx_byte;
         end else if (step) begin
            in_valid_ff <= 1'b0;
         end
         if (step) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= rsp_in;
            count_ff     <= count_in;
            toggle_ff    <= toggle_in;
            type_ff      <= type_in;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.byte_kept    = rsp_data_ff.byte_kept;
   assign rsp_ch.keep_index   = rsp_data_ff.keep_index;
   assign rsp_ch.kept_value   = rsp_data_ff.kept_value;
   assign rsp_ch.frame_event  = rsp_data_ff.frame_event;
   assign rsp_ch.frame_length = rsp_data_ff.frame_length;
   assign rsp_ch.message_id   = rsp_data_ff.message_id;
   assign rsp_ch.known_type   = rsp_data_ff.known_type;
endmodule

FILE: rtl/dsfr_checker.sv
// port-level checks for the frame receiver, bound to the top level
`include "dle_stuffed_frame_receiver_core_defines.svh"

module dsfr_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          byte_kept,
   input logic [dsfr_pkg::INDEX_W-1:0]  keep_index,
   input logic [7:0]                    kept_value,
   input logic [1:0]                    frame_event,
   input logic [dsfr_pkg::LENGTH_W-1:0] frame_length,
   input logic [7:0]                    message_id,
   input logic                          known_type
);
   // a stalled item holds its event and kept byte
   `DSFR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(frame_event) && $stable(kept_value), "stalled item changed")

   // a frame ends on a stored end byte
   `DSFR_ASSERT_NOW(a_complete_end, rsp_valid && frame_event == dsfr_pkg::EV_COMPLETE,
      byte_kept && kept_value == dsfr_pkg::END_BYTE, "complete without stored end byte")

   // overflow only follows a stored byte
   `DSFR_ASSERT_NOW(a_overflow_kept, rsp_valid && frame_event == dsfr_pkg::EV_OVERFLOW,
      byte_kept, "overflow on a dropped byte")

   // frame details only come with a completed frame
   `DSFR_ASSERT_NOW(a_detail_quiet, rsp_valid && frame_event != dsfr_pkg::EV_COMPLETE,
      frame_length == '0 && message_id == '0 && !known_type, "frame details outside complete")

   // a dropped byte reports no position or value
   `DSFR_ASSERT_NOW(a_drop_quiet, rsp_valid && !byte_kept,
      keep_index == '0 && kept_value == '0, "dropped byte reports position")
endmodule

bind dle_stuffed_frame_receiver_core dsfr_checker u_dsfr_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .byte_kept    (rsp_ch.byte_kept),
   .keep_index   (rsp_ch.keep_index),
   .kept_value   (rsp_ch.kept_value),
   .frame_event  (rsp_ch.frame_event),
   .frame_length (rsp_ch.frame_length),
   .message_id   (rsp_ch.message_id),
   .known_type   (rsp_ch.known_type)
);
